// ===== sv/csst_pkg.sv =====
// ----------------------------------------------------------------------------
// csst_pkg: shared types and codes for the centrifuge stop self-test
// Holds the register file, state and per-tick types plus the output codes.
// ----------------------------------------------------------------------------
package csst_pkg;

   localparam int SPEED_W   = 19;
   localparam int CURRENT_W = 16;
   localparam int MS_W      = 16;
   localparam int TIME_W    = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 19;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_OPEN_SPEED       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_STOP_CURRENT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_ERROR_TIME   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SHUTDOWN_DUR     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RISE_TIME        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_STABLE_TIME      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MOTION_THRESHOLD = 3'd6;

   // register reset values
   localparam logic [SPEED_W-1:0]   RST_OPEN_SPEED       = 19'd6000;
   localparam logic [CURRENT_W-1:0] RST_MAX_STOP_CURRENT = 16'd300;
   localparam logic [MS_W-1:0]      RST_MAX_ERROR_TIME   = 16'd1000;
   localparam logic [MS_W-1:0]      RST_SHUTDOWN_DUR     = 16'd3000;
   localparam logic [MS_W-1:0]      RST_RISE_TIME        = 16'd6000;
   localparam logic [MS_W-1:0]      RST_STABLE_TIME      = 16'd500;
   localparam logic [SPEED_W-1:0]   RST_MOTION_THRESHOLD = 19'd10;

   // speed orders
   localparam logic [1:0] SPD_NONE    = 2'd0;
   localparam logic [1:0] SPD_ALERT   = 2'd1;
   localparam logic [1:0] SPD_RELEASE = 2'd2;
   localparam logic [1:0] SPD_INHIBIT = 2'd3;

   // power requests
   localparam logic [1:0] PWR_NONE    = 2'd0;
   localparam logic [1:0] PWR_ENABLE  = 2'd1;
   localparam logic [1:0] PWR_DISABLE = 2'd2;

   // failure causes
   localparam logic [2:0] FAIL_NONE    = 3'd0;
   localparam logic [2:0] FAIL_MOTION  = 3'd1;
   localparam logic [2:0] FAIL_CURRENT = 3'd2;
   localparam logic [2:0] FAIL_ERROR   = 3'd3;
   localparam logic [2:0] FAIL_DIP     = 3'd4;
   localparam logic [2:0] FAIL_RISE    = 3'd5;

   typedef struct packed {
      logic [SPEED_W-1:0]   open_speed;
      logic [CURRENT_W-1:0] max_stop_current;
      logic [MS_W-1:0]      max_error_time_ms;
      logic [MS_W-1:0]      shutdown_duration_ms;
      logic [MS_W-1:0]      rise_time_ms;
      logic [MS_W-1:0]      stable_time_ms;
      logic [SPEED_W-1:0]   motion_threshold;
   } cfg_type;

   typedef struct packed {
      logic              started;
      logic              voltage_done;
      logic              shutdown_done;
      logic              passed;
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] ok_time;
   } state_type;

   typedef struct packed {
      logic                 mode;
      logic [TIME_W-1:0]    now_ms;
      logic                 door_open;
      logic                 door_locked;
      logic                 alarm_active;
      logic [SPEED_W-1:0]   motor_speed;
      logic [CURRENT_W-1:0] motor_current;
      logic                 supply_ok;
      logic                 switched_supply_ok;
      logic                 motor_error;
   } tick_type;

   typedef struct packed {
      logic [1:0] speed_order;
      logic       lock_request;
      logic [1:0] power_request;
      logic       raise_alarm;
      logic [2:0] fail_cause;
      logic       pass_status;
      logic       running;
   } result_type;

endpackage

// ===== sv/csst_step.sv =====
// ----------------------------------------------------------------------------
// csst_step: one tick of the stop self-test sequence
// Works out the next test state and the result item for one sensor tick.
// ----------------------------------------------------------------------------
module csst_step (
   input  csst_pkg::cfg_type    cfg,
   input  csst_pkg::state_type  state,
   input  csst_pkg::tick_type   tick,
   output csst_pkg::state_type  state_next,
   output csst_pkg::result_type result
);

   logic                          arm_ok;
   logic                          start_now;
   logic                          started_eff;
   logic                          vd_eff;
   logic                          sd_eff;
   logic [csst_pkg::TIME_W-1:0]   t0_eff;
   logic [csst_pkg::TIME_W-1:0]   total;
   logic [csst_pkg::TIME_W-1:0]   stop_t;
   logic                          watching;
   logic                          do_watch;
   logic                          supplies_ok;
   logic                          cur_low;
   logic                          f_motion;
   logic                          f_current;
   logic                          f_error;
   logic                          f_dip;
   logic                          f_rise;
   logic                          vd_new;
   logic                          sd_new;

   assign arm_ok    = !tick.door_open && !tick.alarm_active
                      && (tick.motor_speed < cfg.open_speed);
   assign start_now = !tick.mode && !state.started && arm_ok && tick.door_locked;

   assign started_eff = state.started || start_now;
   assign vd_eff      = start_now ? 1'b0 : state.voltage_done;
   assign sd_eff      = start_now ? 1'b0 : state.shutdown_done;
   assign t0_eff      = start_now ? tick.now_ms : state.start_time;

   assign total    = tick.now_ms - t0_eff;
   assign stop_t   = vd_eff ? (tick.now_ms - state.ok_time) : '0;
   assign watching = vd_eff && !sd_eff;
   assign do_watch = started_eff && !tick.alarm_active
                     && (tick.motor_speed < cfg.open_speed);

   assign supplies_ok = tick.supply_ok && tick.switched_supply_ok;
   assign cur_low     = tick.motor_current <= cfg.max_stop_current;

   assign f_motion  = tick.motor_speed > cfg.motion_threshold;
   assign f_current = watching && !cur_low;
   assign f_error   = watching && tick.motor_error
                      && (stop_t > {16'd0, cfg.max_error_time_ms});
   assign f_dip     = watching && !supplies_ok
                      && (stop_t > {16'd0, cfg.stable_time_ms});
   assign f_rise    = !vd_eff && !(supplies_ok && cur_low)
                      && (total > {16'd0, cfg.rise_time_ms});

   // stop_t stays as sampled at the start of the tick, even on the release tick
   assign vd_new = vd_eff || (supplies_ok && cur_low);
   assign sd_new = sd_eff || (vd_new && (stop_t >= {16'd0, cfg.shutdown_duration_ms}));

   always_comb begin
      state_next           = state;
      result               = '0;
      result.speed_order   = csst_pkg::SPD_NONE;
      result.power_request = csst_pkg::PWR_NONE;
      result.fail_cause    = csst_pkg::FAIL_NONE;

      if (tick.mode) begin
         result.power_request = csst_pkg::PWR_DISABLE;
         if (state.passed) begin
            result.speed_order = csst_pkg::SPD_RELEASE;
         end else begin
            state_next.started = 1'b0;
         end
      end else begin
         if (!state.started) begin
            if (arm_ok) begin
               result.lock_request = 1'b1;
            end else begin
               result.speed_order = csst_pkg::SPD_ALERT;
            end
         end
         if (start_now) begin
            state_next.start_time    = tick.now_ms;
            state_next.voltage_done  = 1'b0;
            state_next.shutdown_done = 1'b0;
            result.speed_order       = csst_pkg::SPD_INHIBIT;
            result.power_request     = csst_pkg::PWR_ENABLE;
         end
         state_next.started = started_eff;

         if (!do_watch) begin
            state_next.started = 1'b0;
         end else if (f_motion || f_current || f_error || f_dip || f_rise) begin
            result.power_request = csst_pkg::PWR_DISABLE;
            result.speed_order   = csst_pkg::SPD_INHIBIT;
            result.raise_alarm   = 1'b1;
            if (f_motion) begin
               result.fail_cause = csst_pkg::FAIL_MOTION;
            end else if (f_current) begin
               result.fail_cause = csst_pkg::FAIL_CURRENT;
            end else if (f_error) begin
               result.fail_cause = csst_pkg::FAIL_ERROR;
            end else if (f_dip) begin
               result.fail_cause = csst_pkg::FAIL_DIP;
            end else begin
               result.fail_cause = csst_pkg::FAIL_RISE;
            end
         end else begin
            if (!vd_eff && supplies_ok && cur_low) begin
               // supplies settled and current low: release the inhibit and start the stop phase
               state_next.voltage_done = 1'b1;
               state_next.ok_time      = tick.now_ms;
               result.speed_order      = csst_pkg::SPD_RELEASE;
            end
            state_next.shutdown_done = sd_new;
            if (sd_new) begin
               state_next.passed = 1'b1;
            end
         end
      end

      result.pass_status = state_next.passed;
      result.running     = state_next.started;
   end

endmodule

// ===== sv/centrifuge_stop_self_test.sv =====
// ----------------------------------------------------------------------------
// centrifuge_stop_self_test: centrifuge stop self-test sequencer
// Runs the door/lock/supply/stop checks on each sensor tick and reports
// one result per tick: speed order, lock and power requests, failure cause.
// ----------------------------------------------------------------------------
//  channel  | ports  | direction | moves
//  ---------+--------+-----------+-----------------------------------
//  request  | req_*  | in        | one sensor tick per transfer
//  response | rsp_*  | out       | one result per tick, in order
//  config   | csr_*  | in        | register write, no wait
//
// A tick waits in the input register, its result is formed from the test state
// combinationally and lands in the result register: one tick per cycle sustained
// while the result channel does not stall. The test state advances when the
// tick moves into the result register. A stalled result holds its register;
// the input register keeps taking ticks while the result register is free.
// Reset clears the test state and loads the register defaults.
// ----------------------------------------------------------------------------
module centrifuge_stop_self_test (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             csr_we,
   input  logic [csst_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [csst_pkg::CSR_DAT_W-1:0]   csr_wdata,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_mode,
   input  logic [csst_pkg::TIME_W-1:0]      req_now_ms,
   input  logic                             req_door_open,
   input  logic                             req_door_locked,
   input  logic                             req_alarm_active,
   input  logic [csst_pkg::SPEED_W-1:0]     req_motor_speed,
   input  logic [csst_pkg::CURRENT_W-1:0]   req_motor_current,
   input  logic                             req_supply_ok,
   input  logic                             req_switched_supply_ok,
   input  logic                             req_motor_error,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_speed_order,
   output logic                             rsp_lock_request,
   output logic [1:0]                       rsp_power_request,
   output logic                             rsp_raise_alarm,
   output logic [2:0]                       rsp_fail_cause,
   output logic                             rsp_pass_status,
   output logic                             rsp_running
);

   csst_pkg::cfg_type    cfg_ff;
   csst_pkg::state_type  state_ff;
   csst_pkg::state_type  state_in;
   csst_pkg::tick_type   tick_ff;
   csst_pkg::tick_type   tick_in;
   csst_pkg::result_type rsp_ff;
   csst_pkg::result_type rsp_in;
   logic                 tick_valid_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_free;
   logic                 advance;
   logic                 req_take;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = tick_valid_ff && rsp_free;
   assign req_stall = tick_valid_ff && !rsp_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      tick_in.mode               = req_mode;
      tick_in.now_ms             = req_now_ms;
      tick_in.door_open          = req_door_open;
      tick_in.door_locked        = req_door_locked;
      tick_in.alarm_active       = req_alarm_active;
      tick_in.motor_speed        = req_motor_speed;
      tick_in.motor_current      = req_motor_current;
      tick_in.supply_ok          = req_supply_ok;
      tick_in.switched_supply_ok = req_switched_supply_ok;
      tick_in.motor_error        = req_motor_error;
   end

   csst_step u_step (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .tick       (tick_ff),
      .state_next (state_in),
      .result     (rsp_in)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.open_speed           <= csst_pkg::RST_OPEN_SPEED;
         cfg_ff.max_stop_current     <= csst_pkg::RST_MAX_STOP_CURRENT;
         cfg_ff.max_error_time_ms    <= csst_pkg::RST_MAX_ERROR_TIME;
         cfg_ff.shutdown_duration_ms <= csst_pkg::RST_SHUTDOWN_DUR;
         cfg_ff.rise_time_ms         <= csst_pkg::RST_RISE_TIME;
         cfg_ff.stable_time_ms       <= csst_pkg::RST_STABLE_TIME;
         cfg_ff.motion_threshold     <= csst_pkg::RST_MOTION_THRESHOLD;
      end else if (csr_we) begin
         unique case (csr_index)
            csst_pkg::REG_OPEN_SPEED: begin
               cfg_ff.open_speed <= csr_wdata;
            end
            csst_pkg::REG_MAX_STOP_CURRENT: begin
               cfg_ff.max_stop_current <= csr_wdata[csst_pkg::CURRENT_W-1:0];
            end
            csst_pkg::REG_MAX_ERROR_TIME: begin
               cfg_ff.max_error_time_ms <= csr_wdata[csst_pkg::MS_W-1:0];
            end
            csst_pkg::REG_SHUTDOWN_DUR: begin
               cfg_ff.shutdown_duration_ms <= csr_wdata[csst_pkg::MS_W-1:0];
            end
            csst_pkg::REG_RISE_TIME: begin
               cfg_ff.rise_time_ms <= csr_wdata[csst_pkg::MS_W-1:0];
            end
            csst_pkg::REG_STABLE_TIME: begin
               cfg_ff.stable_time_ms <= csr_wdata[csst_pkg::MS_W-1:0];
            end
            csst_pkg::REG_MOTION_THRESHOLD: begin
               cfg_ff.motion_threshold <= csr_wdata;
            end
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   // test state advances with each tick that moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_valid_ff <= 1'b0;
      end else if (req_take) begin
         tick_valid_ff <= 1'b1;
      end else if (advance) begin
         tick_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         tick_ff <= tick_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= tick_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_speed_order   = rsp_ff.speed_order;
   assign rsp_lock_request  = rsp_ff.lock_request;
   assign rsp_power_request = rsp_ff.power_request;
   assign rsp_raise_alarm   = rsp_ff.raise_alarm;
   assign rsp_fail_cause    = rsp_ff.fail_cause;
   assign rsp_pass_status   = rsp_ff.pass_status;
   assign rsp_running       = rsp_ff.running;

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: centrifuge stop self-test checker
// Drives sensor ticks through the request channel with bursty timing, stalls
// the result channel on its own pattern, and checks every result against a
// cycle-free model of the stop-test sequence kept beside the block. Runs a
// short directed sequence, then whole test sessions with random content and
// injected faults under several register settings.
// ----------------------------------------------------------------------------
module testbench;
   import csst_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   logic     req_valid = 1'b0;
   logic     req_stall;
   tick_type req_item  = '0;

   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_speed_order;
   logic       rsp_lock_request;
   logic [1:0] rsp_power_request;
   logic       rsp_raise_alarm;
   logic [2:0] rsp_fail_cause;
   logic       rsp_pass_status;
   logic       rsp_running;

   centrifuge_stop_self_test dut (
      .clock                  (clock),
      .reset                  (reset),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_mode               (req_item.mode),
      .req_now_ms             (req_item.now_ms),
      .req_door_open          (req_item.door_open),
      .req_door_locked        (req_item.door_locked),
      .req_alarm_active       (req_item.alarm_active),
      .req_motor_speed        (req_item.motor_speed),
      .req_motor_current      (req_item.motor_current),
      .req_supply_ok          (req_item.supply_ok),
      .req_switched_supply_ok (req_item.switched_supply_ok),
      .req_motor_error        (req_item.motor_error),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_speed_order        (rsp_speed_order),
      .rsp_lock_request       (rsp_lock_request),
      .rsp_power_request      (rsp_power_request),
      .rsp_raise_alarm        (rsp_raise_alarm),
      .rsp_fail_cause         (rsp_fail_cause),
      .rsp_pass_status        (rsp_pass_status),
      .rsp_running            (rsp_running)
   );

   always #5 clock = ~clock;

   // model copy of the registers and the test state
   cfg_type   limits;
   state_type test_state;

   tick_type   tick_queue[$];
   result_type predicted_results[$];
   int         error_count = 0;
   logic [TIME_W-1:0] gen_ms = '0;

   // --------------------------------------------------------------------
   // stop-test model: one result per tick
   // --------------------------------------------------------------------
   function automatic result_type stop_test_step(input tick_type t);
      result_type        r;
      logic [TIME_W-1:0] total;
      logic [TIME_W-1:0] stop_t;
      logic              watching;
      logic [2:0]        cause;
      r = '0;
      if (t.mode) begin
         r.power_request = PWR_DISABLE;
         if (test_state.passed) begin
            r.speed_order = SPD_RELEASE;
         end else begin
            test_state.started = 1'b0;
         end
      end else begin
         if (!test_state.started) begin
            if (!t.door_open && !t.alarm_active && t.motor_speed < limits.open_speed) begin
               r.lock_request = 1'b1;
               if (t.door_locked) begin
                  test_state.start_time    = t.now_ms;
                  test_state.voltage_done  = 1'b0;
                  test_state.shutdown_done = 1'b0;
                  r.speed_order            = SPD_INHIBIT;
                  r.power_request          = PWR_ENABLE;
                  test_state.started       = 1'b1;
               end
            end else begin
               r.speed_order = SPD_ALERT;
            end
         end
         if (test_state.started && !t.alarm_active && t.motor_speed < limits.open_speed) begin
            // stop time uses the release state at the start of the tick
            total    = t.now_ms - test_state.start_time;
            stop_t   = test_state.voltage_done ? t.now_ms - test_state.ok_time : '0;
            watching = test_state.voltage_done && !test_state.shutdown_done;
            cause    = FAIL_NONE;
            if (t.motor_speed > limits.motion_threshold) begin
               cause = FAIL_MOTION;
            end else if (watching && t.motor_current > limits.max_stop_current) begin
               cause = FAIL_CURRENT;
            end else if (watching && stop_t > limits.max_error_time_ms && t.motor_error) begin
               cause = FAIL_ERROR;
            end else if (watching && stop_t > limits.stable_time_ms &&
                         !(t.supply_ok && t.switched_supply_ok)) begin
               cause = FAIL_DIP;
            end else if (!test_state.voltage_done) begin
               if (t.supply_ok && t.switched_supply_ok &&
                   t.motor_current <= limits.max_stop_current) begin
                  test_state.voltage_done = 1'b1;
                  test_state.ok_time      = t.now_ms;
                  r.speed_order           = SPD_RELEASE;
               end else if (total > limits.rise_time_ms) begin
                  cause = FAIL_RISE;
               end
            end
            if (cause != FAIL_NONE) begin
               r.power_request = PWR_DISABLE;
               r.speed_order   = SPD_INHIBIT;
               r.raise_alarm   = 1'b1;
               r.fail_cause    = cause;
            end else begin
               if (test_state.voltage_done && stop_t >= limits.shutdown_duration_ms)
                  test_state.shutdown_done = 1'b1;
               if (test_state.voltage_done && test_state.shutdown_done)
                  test_state.passed = 1'b1;
            end
         end else begin
            test_state.started = 1'b0;
         end
      end
      r.pass_status = test_state.passed;
      r.running     = test_state.started;
      return r;
   endfunction

   // --------------------------------------------------------------------
   // stimulus helpers
   // --------------------------------------------------------------------
   function automatic tick_type tick_of(input logic m, input logic [TIME_W-1:0] now,
                                        input logic dopen, input logic dlock,
                                        input logic alarm, input logic [SPEED_W-1:0] spd,
                                        input logic [CURRENT_W-1:0] cur, input logic sup,
                                        input logic swsup, input logic merr);
      tick_type t;
      t.mode               = m;
      t.now_ms             = now;
      t.door_open          = dopen;
      t.door_locked        = dlock;
      t.alarm_active       = alarm;
      t.motor_speed        = spd;
      t.motor_current      = cur;
      t.supply_ok          = sup;
      t.switched_supply_ok = swsup;
      t.motor_error        = merr;
      return t;
   endfunction

   function automatic tick_type noise_tick();
      logic [TIME_W-1:0] now;
      now = ($urandom_range(0, 3) == 0) ? $urandom : gen_ms + $urandom_range(0, 100);
      return tick_of($urandom_range(0, 3) == 0, now, $urandom_range(0, 1),
                     $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 400000),
                     $urandom_range(0, 65535), $urandom_range(0, 1), $urandom_range(0, 1),
                     $urandom_range(0, 1));
   endfunction

   // speed that neither counts as motion nor, with a nonzero open speed, blocks the test
   function automatic logic [SPEED_W-1:0] quiet_speed();
      logic [SPEED_W-1:0] top;
      top = limits.motion_threshold;
      if (limits.open_speed != 0 && top >= limits.open_speed)
         top = limits.open_speed - 1'b1;
      return $urandom_range(0, top);
   endfunction

   function automatic logic [CURRENT_W-1:0] quiet_current();
      return $urandom_range(0, limits.max_stop_current);
   endfunction

   // one session: door checks, start, rise, release, watch, optional exit, with injected faults
   task automatic queue_session();
      tick_type          t;
      int unsigned       rise_ticks;
      int unsigned       past;
      int unsigned       d;
      int unsigned       step;
      int unsigned       tgt;
      logic [TIME_W-1:0] rel;
      logic              good;
      repeat ($urandom_range(0, 2)) begin
         t = noise_tick();
         t.mode = 1'b0;
         tick_queue.push_back(t);
      end
      if ($urandom_range(0, 1))
         tick_queue.push_back(tick_of(0, gen_ms, 0, 0, 0, quiet_speed(), quiet_current(),
                                      1, 1, 0));
      gen_ms += $urandom_range(1, 50);
      rise_ticks = $urandom_range(0, 3);
      good = (rise_ticks == 0);
      tick_queue.push_back(tick_of(0, gen_ms, 0, 1, 0, quiet_speed(), quiet_current(),
                                   good || $urandom_range(0, 1), good,
                                   $urandom_range(0, 1)));
      rel = gen_ms;
      if (rise_ticks != 0) begin
         repeat (rise_ticks - 1) begin
            gen_ms += $urandom_range(0, limits.rise_time_ms / 2 + 1);
            if ($urandom_range(0, 9) == 0)
               gen_ms += limits.rise_time_ms + 1;
            t = tick_of(0, gen_ms, 0, 1, 0, quiet_speed(), quiet_current(), 1, 1,
                        $urandom_range(0, 1));
            case ($urandom_range(0, 3))
               0: t.supply_ok = 1'b0;
               1: t.switched_supply_ok = 1'b0;
               2: begin
                  t.supply_ok = 1'b0;
                  t.switched_supply_ok = 1'b0;
               end
               default: begin
                  if (limits.max_stop_current != '1)
                     t.motor_current = limits.max_stop_current + 1'b1;
                  else
                     t.supply_ok = 1'b0;
               end
            endcase
            tick_queue.push_back(t);
         end
         gen_ms += $urandom_range(0, limits.rise_time_ms / 2 + 1);
         tick_queue.push_back(tick_of(0, gen_ms, 0, 1, 0, quiet_speed(), quiet_current(),
                                      1, 1, $urandom_range(0, 1)));
         rel = gen_ms;
      end
      // watch phase: offsets from release, hitting the thresholds now and then
      d = 0;
      past = 0;
      while (past < 2) begin
         step = $urandom_range(1, limits.shutdown_duration_ms / 5 + 1);
         case ($urandom_range(0, 5))
            0: tgt = limits.stable_time_ms + $urandom_range(0, 1);
            1: tgt = limits.max_error_time_ms + $urandom_range(0, 1);
            2: tgt = limits.shutdown_duration_ms - $urandom_range(0, 1);
            default: tgt = d + step;
         endcase
         d = (tgt > d) ? tgt : d + step;
         if (d >= limits.shutdown_duration_ms)
            past++;
         t = tick_of(0, rel + d, $urandom_range(0, 1), 1, 0, quiet_speed(), quiet_current(),
                     1, 1, (d <= limits.max_error_time_ms) ? $urandom_range(0, 1) : 1'b0);
         if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 5))
               0: t.motor_speed = limits.motion_threshold + 1'b1;
               1: t.motor_current = limits.max_stop_current + 1'b1;
               2: t.motor_error = 1'b1;
               3: t.supply_ok = 1'b0;
               4: t.switched_supply_ok = 1'b0;
               default: t.alarm_active = 1'b1;
            endcase
         end
         tick_queue.push_back(t);
      end
      gen_ms = rel + d;
      if ($urandom_range(0, 3) != 0) begin
         t = noise_tick();
         t.mode = 1'b1;
         tick_queue.push_back(t);
      end
   endtask

   // write all seven registers, one per cycle, while the block is idle
   task automatic load_limits(input cfg_type c);
      logic [CSR_IDX_W-1:0] idx[7];
      logic [CSR_DAT_W-1:0] val[7];
      idx[0] = REG_OPEN_SPEED;       val[0] = c.open_speed;
      idx[1] = REG_MAX_STOP_CURRENT; val[1] = c.max_stop_current;
      idx[2] = REG_MAX_ERROR_TIME;   val[2] = c.max_error_time_ms;
      idx[3] = REG_SHUTDOWN_DUR;     val[3] = c.shutdown_duration_ms;
      idx[4] = REG_RISE_TIME;        val[4] = c.rise_time_ms;
      idx[5] = REG_STABLE_TIME;      val[5] = c.stable_time_ms;
      idx[6] = REG_MOTION_THRESHOLD; val[6] = c.motion_threshold;
      @(posedge clock);
      for (int i = 0; i < 7; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      limits = c;
   endtask

   task automatic wait_drained();
      while (tick_queue.size() != 0 || req_valid || predicted_results.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // --------------------------------------------------------------------
   // sequence
   // --------------------------------------------------------------------
   initial begin
      logic [TIME_W-1:0] d0;
      logic [TIME_W-1:0] t1;
      cfg_type           c;
      int unsigned       goal;
      int unsigned       queued;
      limits = '{RST_OPEN_SPEED, RST_MAX_STOP_CURRENT, RST_MAX_ERROR_TIME,
                 RST_SHUTDOWN_DUR, RST_RISE_TIME, RST_STABLE_TIME, RST_MOTION_THRESHOLD};
      test_state = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // directed: door checks, rise timeout, each failure, pass, exits, time wrap
      d0 = 32'hFFFF_F000;
      t1 = d0 + 8000;
      tick_queue.push_back(tick_of(0, d0,      1, 0, 0, 0, 0, 0, 0, 0));
      tick_queue.push_back(tick_of(0, d0 + 1,  0, 0, 1, 0, 0, 0, 0, 0));
      tick_queue.push_back(tick_of(0, d0 + 2,  0, 0, 0, 400000, 0, 0, 0, 0));
      tick_queue.push_back(tick_of(0, d0 + 3,  0, 0, 0, 0, 0, 0, 0, 0));
      tick_queue.push_back(tick_of(0, d0 + 10, 0, 1, 0, 5, 0, 0, 1, 0));
      tick_queue.push_back(tick_of(0, d0 + 7000, 0, 1, 0, 0, 0, 1, 0, 0));
      tick_queue.push_back(tick_of(1, d0 + 7100, 0, 1, 0, 0, 0, 0, 0, 0));
      tick_queue.push_back(tick_of(0, t1,        0, 1, 0, 0, 300, 1, 1, 0));
      tick_queue.push_back(tick_of(0, t1 + 100,  0, 1, 0, 0, 301, 1, 1, 0));
      tick_queue.push_back(tick_of(0, t1 + 200,  0, 1, 0, 11, 0, 1, 1, 0));
      tick_queue.push_back(tick_of(0, t1 + 1000, 0, 1, 0, 0, 0, 1, 1, 1));
      tick_queue.push_back(tick_of(0, t1 + 1001, 0, 1, 0, 0, 0, 1, 1, 1));
      tick_queue.push_back(tick_of(0, t1 + 1100, 0, 1, 0, 0, 0, 0, 1, 0));
      tick_queue.push_back(tick_of(0, t1 + 1200, 0, 1, 0, 0, 0, 1, 0, 0));
      tick_queue.push_back(tick_of(0, t1 + 2999, 0, 1, 0, 0, 0, 1, 1, 0));
      tick_queue.push_back(tick_of(0, t1 + 3000, 0, 1, 0, 0, 0, 1, 1, 0));
      tick_queue.push_back(tick_of(0, t1 + 3100, 1, 1, 0, 10, 65535, 0, 1, 1));
      tick_queue.push_back(tick_of(1, t1 + 3200, 0, 1, 0, 0, 0, 1, 1, 0));
      tick_queue.push_back(tick_of(0, t1 + 3300, 0, 1, 0, 6000, 0, 1, 1, 0));
      tick_queue.push_back(tick_of(0, 32'hFFFF_FFFF, 0, 1, 0, 10, 300, 1, 1, 1));
      tick_queue.push_back(tick_of(1, 32'hFFFF_FFFF, 1, 1, 1, 400000, 65535, 1, 1, 1));
      tick_queue.push_back(tick_of(0, 32'hFFFF_FFFF, 1, 1, 1, 400000, 65535, 1, 1, 1));
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         c.open_speed           = $urandom_range(1000, 400000);
         c.max_stop_current     = $urandom_range(0, 65535);
         c.max_error_time_ms    = $urandom_range(0, 65535);
         c.shutdown_duration_ms = $urandom_range(0, 65535);
         c.rise_time_ms         = $urandom_range(0, 65535);
         c.stable_time_ms       = $urandom_range(0, 65535);
         c.motion_threshold     = $urandom_range(0, 2000);
         goal = 300;
         case (p)
            1: begin
               c = '0;
               goal = 100;
            end
            3: c = '{19'd400000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     19'd400000};
            4: c = '{RST_OPEN_SPEED, RST_MAX_STOP_CURRENT, RST_MAX_ERROR_TIME,
                     RST_SHUTDOWN_DUR, RST_RISE_TIME, RST_STABLE_TIME,
                     RST_MOTION_THRESHOLD};
            6: begin
               // short times: exact threshold offsets come up often
               c.max_error_time_ms    = $urandom_range(0, 20);
               c.shutdown_duration_ms = $urandom_range(0, 40);
               c.rise_time_ms         = $urandom_range(0, 20);
               c.stable_time_ms       = $urandom_range(0, 20);
            end
            default: ;
         endcase
         load_limits(c);
         gen_ms = (p % 2 != 0) ? 32'hFFFF_0000 + $urandom_range(0, 65535) : $urandom;
         queued = 0;
         while (queued < goal) begin
            if ($urandom_range(0, 5) == 0) begin
               tick_queue.push_back(noise_tick());
               queued++;
            end else begin
               queued -= tick_queue.size();
               queue_session();
               queued += tick_queue.size();
            end
         end
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #5000000;
      $display("FAILURE");
      $finish;
   end

   // --------------------------------------------------------------------
   // driver: bursts of transfers with random gaps
   // --------------------------------------------------------------------
   int unsigned burst_left = 1;
   int unsigned gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            predicted_results.push_back(stop_test_step(req_item));
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (tick_queue.size() != 0) begin
               req_item  <= tick_queue.pop_front();
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 2) != 0) ? $urandom_range(1, 8) : 0;
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // --------------------------------------------------------------------
   // receiver stall pattern, with a periodic long hold
   // --------------------------------------------------------------------
   int unsigned rx_cycle  = 0;
   int unsigned hold_left = 0;
   int unsigned stall_pct = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rx_cycle++;
         if (rx_cycle % 64 == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 10;
               2: stall_pct = 40;
               default: stall_pct = 75;
            endcase
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rx_cycle % 3000 == 700) begin
            hold_left = 150;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // --------------------------------------------------------------------
   // monitor
   // --------------------------------------------------------------------
   task automatic check_field(input string name, input int unsigned exp_v,
                              input int unsigned act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_results.size() == 0) begin
            $display("%0t: result transfer with nothing expected, expected none, actual %p",
                     $time, {rsp_speed_order, rsp_lock_request, rsp_power_request,
                             rsp_raise_alarm, rsp_fail_cause, rsp_pass_status, rsp_running});
            error_count++;
         end else begin
            e = predicted_results.pop_front();
            check_field("speed_order",   e.speed_order,   rsp_speed_order);
            check_field("lock_request",  e.lock_request,  rsp_lock_request);
            check_field("power_request", e.power_request, rsp_power_request);
            check_field("raise_alarm",   e.raise_alarm,   rsp_raise_alarm);
            check_field("fail_cause",    e.fail_cause,    rsp_fail_cause);
            check_field("pass_status",   e.pass_status,   rsp_pass_status);
            check_field("running",       e.running,       rsp_running);
         end
      end
   end

endmodule
